### hw/rtl/prt_pkg.sv
// Shared types and constants for the pending request table with timeout.
// Used by prt_ctrl and pending_request_table_with_timeout_top.
package prt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] TIMEOUT_RESET = 32'd10800;

  localparam logic CMD_REQUEST   = 1'b0;
  localparam logic CMD_RECEPTION = 1'b1;

  // One table entry as it is held in the memory.
  typedef struct packed {
    logic [31:0] asset_type;
    logic [31:0] asset_id;
    logic [31:0] asset_crc;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One input transaction, as latched by the controller.
  typedef struct packed {
    logic        command;
    logic [31:0] asset_type;
    logic [31:0] asset_id;
    logic [31:0] asset_crc;
    logic [31:0] now_ticks;
  } req_t;

  // Control side of the table memory port.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } mem_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_FINISH
  } state_t;

endpackage

### hw/rtl/prt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module prt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/prt_ctrl.sv
// Table sequencer: match scan, in-place compaction, append and result register.
// Depends on prt_pkg; drives the table memory in prt_ram.
module prt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  prt_pkg::req_t     req,
  input  logic [31:0]       timeout,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [6:0]        pending_count,
  output prt_pkg::mem_cmd_t mem_cmd,
  output prt_pkg::entry_t   mem_wr_data,
  input  prt_pkg::entry_t   mem_rd_data
);
  import prt_pkg::*;

  state_t           state, state_next;
  req_t             req_q, req_q_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             rd_pend, rd_pend_next;
  logic [CNT_W-1:0] wr_idx, wr_idx_next;
  logic             hit_q, hit_q_next;
  logic             out_valid_next;
  logic             hit_next;
  logic [6:0]       pending_count_next;

  logic             match;
  logic [31:0]      age;
  logic             keep;
  logic             full;
  logic             hit_now;
  logic             scan_end;
  logic             compact_end;
  logic             slot_free;

  // Compare the entry just read against the latched key.
  assign match = (mem_rd_data.asset_type == req_q.asset_type) &&
                 (mem_rd_data.asset_id == req_q.asset_id) &&
                 ((mem_rd_data.asset_crc == 32'd0) || (req_q.asset_crc == 32'd0) ||
                  (mem_rd_data.asset_crc == req_q.asset_crc));

  // Wrapping age; a reception keeps every entry behind the removed one.
  assign age  = req_q.now_ticks - mem_rd_data.stamp;
  assign keep = (req_q.command == CMD_RECEPTION) || !(age > timeout);
  assign full = (cnt == CNT_W'(TABLE_DEPTH));

  assign hit_now     = (state == ST_SCAN) && rd_pend && match;
  assign scan_end    = (state == ST_SCAN) && !rd_pend && (rd_idx >= cnt);
  assign compact_end = (state == ST_COMPACT) && !rd_pend && (rd_idx >= cnt);
  assign slot_free   = !out_valid || out_ready;

  assign in_ready = (state == ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          state_next = (req_q.command == CMD_RECEPTION) ? ST_COMPACT : ST_FINISH;
        end else if (scan_end) begin
          state_next = (req_q.command == CMD_REQUEST) ? ST_COMPACT : ST_FINISH;
        end
      end
      ST_COMPACT: begin
        if (compact_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and memory control. Reads always run ahead of writes during
  // compaction (write index below read index), so no forwarding is needed.
  always_comb begin
    req_q_next         = req_q;
    cnt_next           = cnt;
    rd_idx_next        = rd_idx;
    rd_pend_next       = 1'b0;
    wr_idx_next        = wr_idx;
    hit_q_next         = hit_q;
    out_valid_next     = out_valid && !out_ready;
    hit_next           = hit;
    pending_count_next = pending_count;
    mem_cmd            = '0;
    mem_wr_data        = mem_rd_data;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_q_next  = req;
          rd_idx_next = '0;
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          hit_q_next = 1'b1;
          // Shift the tail down over the matching entry.
          wr_idx_next = rd_idx - CNT_W'(1);
        end else if (scan_end) begin
          hit_q_next = 1'b0;
          // A full table drops its oldest entry by starting past it.
          rd_idx_next = full ? CNT_W'(1) : '0;
          wr_idx_next = '0;
        end else if (rd_idx < cnt) begin
          mem_cmd.rd_en   = 1'b1;
          mem_cmd.rd_addr = rd_idx[IDX_W-1:0];
          rd_idx_next     = rd_idx + CNT_W'(1);
          rd_pend_next    = 1'b1;
        end
      end
      ST_COMPACT: begin
        if (rd_pend && keep) begin
          mem_cmd.wr_en   = 1'b1;
          mem_cmd.wr_addr = wr_idx[IDX_W-1:0];
          wr_idx_next     = wr_idx + CNT_W'(1);
        end
        if (compact_end) begin
          if (req_q.command == CMD_REQUEST) begin
            // Append the new request behind the surviving entries.
            mem_cmd.wr_en          = 1'b1;
            mem_cmd.wr_addr        = wr_idx[IDX_W-1:0];
            mem_wr_data.asset_type = req_q.asset_type;
            mem_wr_data.asset_id   = req_q.asset_id;
            mem_wr_data.asset_crc  = req_q.asset_crc;
            mem_wr_data.stamp      = req_q.now_ticks;
            cnt_next               = wr_idx + CNT_W'(1);
          end else begin
            cnt_next = wr_idx;
          end
        end else if (rd_idx < cnt) begin
          mem_cmd.rd_en   = 1'b1;
          mem_cmd.rd_addr = rd_idx[IDX_W-1:0];
          rd_idx_next     = rd_idx + CNT_W'(1);
          rd_pend_next    = 1'b1;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_next     = 1'b1;
          hit_next           = hit_q;
          pending_count_next = 7'(cnt);
        end
      end
      default: begin
        out_valid_next = out_valid && !out_ready;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_q         <= req_q_next;
    rd_idx        <= rd_idx_next;
    wr_idx        <= wr_idx_next;
    hit_q         <= hit_q_next;
    hit           <= hit_next;
    pending_count <= pending_count_next;
  end

  // The table never holds more entries than it has rows.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // Compaction writes stay strictly behind the read pointer.
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPACT) && mem_cmd.rd_en && mem_cmd.wr_en |->
      (mem_cmd.wr_addr < mem_cmd.rd_addr))
    else $error("compaction write overtook read");

  // No memory read is outstanding when a new transaction can be taken.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !rd_pend)
    else $error("read in flight while idle");

  // A request that misses always leaves at least its own entry behind.
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    compact_end && (req_q.command == CMD_REQUEST) |=> (cnt != '0))
    else $error("request miss left empty table");

endmodule

### hw/rtl/pending_request_table_with_timeout_top.sv
// Top level of the pending request table with timeout: timeout register,
// table memory and sequencer. Depends on prt_pkg, prt_ram and prt_ctrl.
// Sequence: after acceptance, a scan for a match, then a compaction pass when a
//   reception hits or a request misses, then the result register (with a full
//   table, a missing request skips its oldest entry during compaction).
// A new transaction is taken only in idle, after the last result is registered;
//   scan and compaction share the single read port of the table memory.
// Reset clears the entry count and sets the timeout to 10800 ticks; the table
//   memory itself is not cleared, since only entries below the count are read.
module pending_request_table_with_timeout_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [31:0]        asset_type,
  input  logic signed [31:0] asset_id,
  input  logic [31:0]        asset_crc,
  input  logic [31:0]        now_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [6:0]         pending_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        timeout_ticks
);
  import prt_pkg::*;

  logic [31:0]        timeout;
  req_t               req;
  mem_cmd_t           mem_cmd;
  entry_t             mem_wr_data;
  entry_t             mem_rd_data;
  logic [ENTRY_W-1:0] rd_bits;

  // Timeout register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout <= timeout_ticks;
    end
  end

  // Gather the input transaction fields.
  assign req.command    = command;
  assign req.asset_type = asset_type;
  assign req.asset_id   = $unsigned(asset_id);
  assign req.asset_crc  = asset_crc;
  assign req.now_ticks  = now_ticks;

  assign mem_rd_data = entry_t'(rd_bits);

  prt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_cmd.rd_en),
    .rd_addr (mem_cmd.rd_addr),
    .rd_data (rd_bits),
    .wr_en   (mem_cmd.wr_en),
    .wr_addr (mem_cmd.wr_addr),
    .wr_data (mem_wr_data)
  );

  prt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req           (req),
    .timeout       (timeout),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .pending_count (pending_count),
    .mem_cmd       (mem_cmd),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_data   (mem_rd_data)
  );

endmodule

### dv/pending_request_table_with_timeout_top_test.sv
// Self-checking testbench for pending_request_table_with_timeout_top.
// Predicts every result with a shadow table kept in the bench itself.
// Depends on prt_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module pending_request_table_with_timeout_top_test;
  import prt_pkg::*;

  localparam int HANG_LIMIT = 10000;

  // Expected content of one result transaction.
  typedef struct packed {
    logic       hit;
    logic [6:0] pending_count;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = CMD_REQUEST;
  logic [31:0]        asset_type = '0;
  logic signed [31:0] asset_id = '0;
  logic [31:0]        asset_crc = '0;
  logic [31:0]        now_ticks = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [6:0]         pending_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        timeout_ticks = '0;

  // Shadow copy of the request table and the timeout register.
  logic [31:0] shadow_type [TABLE_DEPTH];
  logic [31:0] shadow_id [TABLE_DEPTH];
  logic [31:0] shadow_crc [TABLE_DEPTH];
  logic [31:0] shadow_stamp [TABLE_DEPTH];
  int          shadow_count = 0;
  logic [31:0] shadow_timeout = TIMEOUT_RESET;

  outcome_t    expected_outcomes[$];
  int          error_count = 0;
  int          stall_cycles = 0;
  int          hold_off_cycles = 0;
  bit          idle_enabled = 1'b1;
  logic [31:0] tick_clock = 32'd1000;

  pending_request_table_with_timeout_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .asset_type    (asset_type),
    .asset_id      (asset_id),
    .asset_crc     (asset_crc),
    .now_ticks     (now_ticks),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .pending_count (pending_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .timeout_ticks (timeout_ticks)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Remove one shadow entry and close the gap, keeping the order.
  function automatic void drop_entry(int k);
    int j;
    for (j = k; j < shadow_count - 1; j++) begin
      shadow_type[j] = shadow_type[j + 1];
      shadow_id[j] = shadow_id[j + 1];
      shadow_crc[j] = shadow_crc[j + 1];
      shadow_stamp[j] = shadow_stamp[j + 1];
    end
    shadow_count--;
  endfunction

  // Apply one command to the shadow table and return the result it produces.
  function automatic outcome_t apply_to_shadow_table(logic cmd, logic [31:0] t,
                                                     logic [31:0] id, logic [31:0] crc,
                                                     logic [31:0] now);
    outcome_t    r;
    int          k;
    logic        found;
    logic [31:0] age;
    found = 1'b0;
    k = 0;
    while (k < shadow_count && !found) begin
      if (shadow_type[k] == t && shadow_id[k] == id &&
          (shadow_crc[k] == 32'd0 || crc == 32'd0 || shadow_crc[k] == crc))
        found = 1'b1;
      else
        k++;
    end
    if (cmd == CMD_RECEPTION) begin
      if (found)
        drop_entry(k);
    end else if (!found) begin
      // A full table loses its oldest entry before the purge.
      if (shadow_count == TABLE_DEPTH)
        drop_entry(0);
      k = 0;
      while (k < shadow_count) begin
        age = now - shadow_stamp[k];
        if (age > shadow_timeout)
          drop_entry(k);
        else
          k++;
      end
      shadow_type[shadow_count] = t;
      shadow_id[shadow_count] = id;
      shadow_crc[shadow_count] = crc;
      shadow_stamp[shadow_count] = now;
      shadow_count++;
    end
    r.hit = found;
    r.pending_count = shadow_count[6:0];
    return r;
  endfunction

  // Offer one input transaction, record its prediction and maybe leave a gap.
  task automatic send_item(logic cmd, logic [31:0] t, logic [31:0] id,
                           logic [31:0] crc, logic [31:0] now);
    in_valid <= 1'b1;
    command <= cmd;
    asset_type <= t;
    asset_id <= id;
    asset_crc <= crc;
    now_ticks <= now;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    expected_outcomes.push_back(apply_to_shadow_table(cmd, t, id, crc, now));
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Random transaction drawn mostly from small key pools so that hits are common.
  task automatic send_random_item();
    logic [31:0] t;
    logic [31:0] id;
    logic [31:0] crc;
    logic        cmd;
    case ($urandom_range(0, 4))
      0: t = 32'h50494354;
      1: t = 32'h534E4420;
      2: t = 32'h00000000;
      3: t = 32'hFFFFFFFF;
      default: t = $urandom();
    endcase
    case ($urandom_range(0, 5))
      0: id = 32'h00000000;
      1: id = 32'h00000001;
      2: id = 32'hFFFFFFFF;
      3: id = 32'h80000000;
      4: id = 32'h7FFFFFFF;
      default: id = $urandom();
    endcase
    case ($urandom_range(0, 3))
      0: crc = 32'd0;
      1, 2: crc = $urandom_range(1, 3);
      default: crc = $urandom();
    endcase
    cmd = ($urandom_range(0, 9) < 6) ? CMD_REQUEST : CMD_RECEPTION;
    // Time mostly creeps forward; now and then it jumps anywhere.
    if ($urandom_range(0, 39) == 0)
      tick_clock = $urandom();
    else
      tick_clock = tick_clock + $urandom_range(0, 250);
    send_item(cmd, t, id, crc, tick_clock);
  endtask

  // Stop offering and wait until every predicted result has been returned.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the timeout register while the block is idle.
  task automatic write_timeout(logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    timeout_ticks <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_timeout = value;
  endtask

  // Hits, wildcards, ordered removal, the timeout boundary and time wrap,
  // all under the timeout left by reset.
  task automatic test_basics();
    send_item(CMD_RECEPTION, 32'h50494354, 32'd5, 32'h11, 32'd1000);
    send_item(CMD_REQUEST, 32'h50494354, 32'd5, 32'h11, 32'd1000);
    send_item(CMD_REQUEST, 32'h50494354, 32'd5, 32'h11, 32'd1000);
    send_item(CMD_REQUEST, 32'h50494354, 32'd5, 32'h0, 32'd1000);
    send_item(CMD_REQUEST, 32'h50494354, 32'd5, 32'h22, 32'd1000);
    send_item(CMD_REQUEST, 32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd1000);
    send_item(CMD_REQUEST, 32'h00000000, 32'h7FFFFFFF, 32'h0, 32'd1000);
    send_item(CMD_RECEPTION, 32'h00000000, 32'h7FFFFFFF, 32'h1234, 32'd1000);
    send_item(CMD_RECEPTION, 32'h50494354, 32'd5, 32'h0, 32'd1000);
    send_item(CMD_RECEPTION, 32'h50494354, 32'd6, 32'h0, 32'd1000);
    // An age equal to the timeout survives; one tick more is purged.
    send_item(CMD_REQUEST, 32'h534E4420, 32'd1, 32'h1, 32'd1000 + TIMEOUT_RESET);
    send_item(CMD_REQUEST, 32'h534E4420, 32'd2, 32'h1, 32'd1001 + TIMEOUT_RESET);
    // Ages are taken modulo 2^32 across the wrap of the tick counter.
    send_item(CMD_REQUEST, 32'h534E4420, 32'd3, 32'h1, 32'hFFFFFF00);
    send_item(CMD_REQUEST, 32'h534E4420, 32'd4, 32'h1, 32'h00000100);
    send_item(CMD_RECEPTION, 32'h534E4420, 32'd3, 32'h1, 32'h00000100);
    send_item(CMD_REQUEST, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(CMD_RECEPTION, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
  endtask

  // Fill the table, overflow it, then purge everything with a zero timeout.
  task automatic test_table_full();
    int i;
    write_timeout(32'hFFFFFFFF);
    for (i = 0; i < TABLE_DEPTH + 1; i++)
      send_item(CMD_REQUEST, 32'h46554C4C, i, i + 1, 32'd5000);
    send_item(CMD_RECEPTION, 32'h46554C4C, 32'd0, 32'd0, 32'd5000);
    send_item(CMD_RECEPTION, 32'h46554C4C, 32'd1, 32'd0, 32'd5000);
    send_item(CMD_REQUEST, 32'h46554C4C, 32'd100, 32'd0, 32'd5000);
    write_timeout(32'd0);
    send_item(CMD_REQUEST, 32'h46554C4C, 32'd101, 32'd0, 32'd5000);
    send_item(CMD_REQUEST, 32'h46554C4C, 32'd102, 32'd0, 32'd5001);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    write_timeout(TIMEOUT_RESET);
    idle_enabled = 1'b0;
    hold_off_cycles = 1500;
    repeat (12) send_random_item();
    idle_enabled = 1'b1;
    settle();
  endtask

  task automatic test_random_traffic(int count, logic [31:0] timeout, bit idle);
    write_timeout(timeout);
    idle_enabled = idle;
    repeat (count) send_random_item();
  endtask

  // Receiver: accepts results, with random stalls and an occasional long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%t: unexpected result, expected none, actual hit=%0d count=%0d",
                 $time, hit, pending_count);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (hit !== want.hit) begin
          $display("%t: hit mismatch, expected %0d, actual %0d", $time, want.hit, hit);
          error_count++;
        end
        if (pending_count !== want.pending_count) begin
          $display("%t: pending_count mismatch, expected %0d, actual %0d",
                   $time, want.pending_count, pending_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= HANG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basics();
    test_table_full();
    test_backpressure();
    test_random_traffic(250, TIMEOUT_RESET, 1'b1);
    test_random_traffic(250, 32'hFFFFFFFF, 1'b1);
    test_random_traffic(200, 32'd0, 1'b1);
    test_random_traffic(250, $urandom_range(300, 5000), 1'b1);
    test_random_traffic(250, $urandom(), 1'b1);
    test_random_traffic(150, TIMEOUT_RESET, 1'b0);
    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
